// File: rtl/bli_pkg.sv
`default_nettype none

package bli_pkg;

    // Width of the signed internal datapath: enough for the difference of two
    // 32-bit values and for a left end value plus a segment step.
    localparam int WW = 34;

    // Width of every fixed-point field on the channels.
    localparam int FIELD_W = 32;

    // Operation codes of a command item.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_POINT_COUNT  = 2'd0;
    localparam logic [1:0] REG_ZERO_OUTSIDE = 2'd1;
    localparam logic [1:0] REG_RANGE_LOW    = 2'd2;
    localparam logic [1:0] REG_RANGE_HIGH   = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_BELOW = 3'd1;
    localparam logic [2:0] ST_ABOVE = 3'd2;
    localparam logic [2:0] ST_EMPTY = 3'd3;
    localparam logic [2:0] ST_SAT   = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_END,
        S_SEARCH,
        S_PROBE,
        S_LOAD0,
        S_LOAD1,
        S_SETUP,
        S_CLAMP,
        S_DIV,
        S_MULH,
        S_MULL,
        S_SUM,
        S_APPLY,
        S_EMIT
    } state_t;

endpackage

`default_nettype wire

// File: rtl/bli_if.sv
`default_nettype none

interface bli_cmd_if
    import bli_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic                       operation;
    logic [5:0]                 point_index;
    logic signed [FIELD_W-1:0]  point_x;
    logic signed [FIELD_W-1:0]  point_y;
    logic signed [FIELD_W-1:0]  query_x;

    modport source (
        output valid, operation, point_index, point_x, point_y, query_x,
        input  ready
    );
    modport sink (
        input  valid, operation, point_index, point_x, point_y, query_x,
        output ready
    );
endinterface

interface bli_result_if
    import bli_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [FIELD_W-1:0]  value;
    logic [2:0]                 status;

    modport source (
        output valid, value, status,
        input  ready
    );
    modport sink (
        input  valid, value, status,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/bli_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module bli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/breakpoint_linear_interpolator.sv
// Channel   Dir  Handshake      Payload
// cmd       in   valid/ready    operation, point_index, point_x, point_y, query_x
// result    out  valid/ready    value, status
// cfg       in   cfg_we only    cfg_index, cfg_data
//
// A write item gives no result. An evaluate item ends without a search for an empty
// table or a zeroed out-of-range query, returns an end value for a single point, an
// out-of-range query or a search that stops at an end, and else interpolates, with at
// most p = floor(log2(n)) + 1 probes; the divide is the longest step of an interpolation.
// Reset is asynchronous and clears configuration and control state, not the memories.
// A result waits in an output register while the next item runs; only the next result
// stalls until it is taken.
`default_nettype none

module breakpoint_linear_interpolator
    import bli_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire                clk,
    input  wire                rst_n,
    bli_cmd_if.sink            cmd,
    bli_result_if.source       result,
    input  wire                cfg_we,
    input  wire [1:0]          cfg_index,
    input  wire [FIELD_W-1:0]  cfg_data
);

    // Stored and computed values use at most 32 bits of value width.
    localparam int VW = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
    // Memory address width and the width of a point count up to the depth.
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    // Common widths for comparing the 7-bit count and the 6-bit slot index
    // against the depth.
    localparam int CW = (NW > 7) ? NW : 7;
    localparam int IW = (NW > 6) ? NW : 6;

    localparam logic signed [WW-1:0] SAT_HI = (WW'(1) <<< (VW - 1)) - WW'(1);
    localparam logic signed [WW-1:0] SAT_LO = -SAT_HI - WW'(1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [6:0]                 point_count_reg;
    logic                       zero_outside_reg;
    logic signed [FIELD_W-1:0]  range_low_reg;
    logic signed [FIELD_W-1:0]  range_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg  <= '0;
            zero_outside_reg <= 1'b0;
            range_low_reg    <= '0;
            range_high_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POINT_COUNT:  point_count_reg  <= cfg_data[6:0];
                REG_ZERO_OUTSIDE: zero_outside_reg <= cfg_data[0];
                REG_RANGE_LOW:    range_low_reg    <= cfg_data;
                REG_RANGE_HIGH:   range_high_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Breakpoint memories. Both share one read address, so each read
    // returns a complete (x, y) point in the following cycle.
    // ------------------------------------------------------------------
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [AW-1:0]  rd_addr;
    logic [VW-1:0]  x_rd;
    logic [VW-1:0]  y_rd;

    bli_ram #(
        .WIDTH (VW),
        .DEPTH (TABLE_DEPTH)
    ) u_x_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (cmd.point_x[VW-1:0]),
        .raddr (rd_addr),
        .rdata (x_rd)
    );

    bli_ram #(
        .WIDTH (VW),
        .DEPTH (TABLE_DEPTH)
    ) u_y_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (cmd.point_y[VW-1:0]),
        .raddr (rd_addr),
        .rdata (y_rd)
    );

    // Sign-extended views of the memory outputs and of the inputs.
    logic signed [WW-1:0] x_rd_s;
    logic signed [WW-1:0] y_rd_s;
    logic signed [WW-1:0] query_s;
    logic signed [WW-1:0] range_low_s;
    logic signed [WW-1:0] range_high_s;

    assign x_rd_s       = {{(WW - VW){x_rd[VW-1]}}, x_rd};
    assign y_rd_s       = {{(WW - VW){y_rd[VW-1]}}, y_rd};
    assign query_s      = {{(WW - VW){cmd.query_x[VW-1]}}, cmd.query_x[VW-1:0]};
    assign range_low_s  = {{(WW - FIELD_W){range_low_reg[FIELD_W-1]}}, range_low_reg};
    assign range_high_s = {{(WW - FIELD_W){range_high_reg[FIELD_W-1]}}, range_high_reg};

    // Points in use: the count register, limited to the table depth.
    logic [CW-1:0] count_ext;
    logic [CW-1:0] n_full;
    logic [NW-1:0] n_cur;
    logic [NW-1:0] n_cur_m1;

    assign count_ext = CW'(point_count_reg);
    assign n_full    = (count_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : count_ext;
    assign n_cur     = n_full[NW-1:0];
    assign n_cur_m1  = n_cur - NW'(1);

    // Write slot, ignored when it lies beyond the table.
    logic [IW-1:0] widx_ext;
    logic          cmd_accept;

    assign widx_ext   = IW'(cmd.point_index);
    assign cmd_accept = cmd.valid && cmd.ready;
    assign mem_we     = cmd_accept && (cmd.operation == OP_WRITE)
                        && (widx_ext < IW'(TABLE_DEPTH));
    assign mem_waddr  = widx_ext[AW-1:0];

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    state_t                 state_reg,  state_next;
    logic signed [WW-1:0]   xq_reg,     xq_next;
    logic [NW-1:0]          n_reg,      n_next;
    logic [NW-1:0]          first_reg,  first_next;
    logic [NW-1:0]          count_reg,  count_next;
    logic [NW-1:0]          step_reg,   step_next;
    logic [AW-1:0]          probe_reg,  probe_next;
    logic [2:0]             st_reg,     st_next;
    logic signed [WW-1:0]   res_reg,    res_next;
    logic signed [WW-1:0]   x0_reg,     x0_next;
    logic signed [WW-1:0]   y0_reg,     y0_next;
    logic signed [WW-1:0]   x1_reg,     x1_next;
    logic signed [WW-1:0]   y1_reg,     y1_next;
    logic signed [WW-1:0]   dx_reg,     dx_next;
    logic signed [WW-1:0]   num_reg,    num_next;
    logic signed [WW-1:0]   delta_reg,  delta_next;
    logic [WW-1:0]          rem_reg,    rem_next;
    logic [31:0]            quo_reg,    quo_next;
    logic [4:0]             iter_reg,   iter_next;
    logic [31:0]            mag_reg,    mag_next;
    logic                   neg_reg,    neg_next;
    logic [47:0]            prod_hi_reg, prod_hi_next;
    logic [47:0]            prod_lo_reg, prod_lo_next;
    logic [32:0]            q_reg,      q_next;

    logic                       out_valid_reg, out_valid_next;
    logic signed [FIELD_W-1:0]  out_value_reg, out_value_next;
    logic [2:0]                 out_status_reg, out_status_next;

    // The one multiplier, fed with the upper or the lower half of the
    // fraction in turn.
    logic [15:0] mul_b;
    logic [47:0] mul_p;

    assign mul_b = (state_reg == S_MULH) ? quo_reg[31:16] : quo_reg[15:0];
    assign mul_p = 48'(mag_reg) * 48'(mul_b);

    // One restoring divide step.
    logic [WW-1:0] rem_sh;
    logic          div_fit;

    assign rem_sh  = {rem_reg[WW-2:0], 1'b0};
    assign div_fit = (rem_sh >= $unsigned(dx_reg));

    logic [NW-1:0] probe_sum;
    logic [NW-1:0] first_m1;
    logic [48:0]   sum_full;
    logic          out_free;

    assign probe_sum = first_reg + (count_reg >> 1);
    assign first_m1  = first_reg - NW'(1);
    assign sum_full  = {1'b0, prod_hi_reg} + 49'(prod_lo_reg >> 16);
    assign out_free  = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next      = state_reg;
        xq_next         = xq_reg;
        n_next          = n_reg;
        first_next      = first_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        probe_next      = probe_reg;
        st_next         = st_reg;
        res_next        = res_reg;
        x0_next         = x0_reg;
        y0_next         = y0_reg;
        x1_next         = x1_reg;
        y1_next         = y1_reg;
        dx_next         = dx_reg;
        num_next        = num_reg;
        delta_next      = delta_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        iter_next       = iter_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        prod_hi_next    = prod_hi_reg;
        prod_lo_next    = prod_lo_reg;
        q_next          = q_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        rd_addr         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept && (cmd.operation == OP_EVAL))
                begin
                    xq_next    = query_s;
                    n_next     = n_cur;
                    first_next = '0;
                    count_next = n_cur;
                    st_next    = ST_OK;
                    res_next   = '0;
                    if (n_cur == '0)
                    begin
                        st_next    = ST_EMPTY;
                        state_next = S_EMIT;
                    end
                    else if (query_s < range_low_s)
                    begin
                        st_next = ST_BELOW;
                        rd_addr = '0;
                        state_next = zero_outside_reg ? S_EMIT : S_END;
                    end
                    else if (query_s > range_high_s)
                    begin
                        st_next = ST_ABOVE;
                        rd_addr = n_cur_m1[AW-1:0];
                        state_next = zero_outside_reg ? S_EMIT : S_END;
                    end
                    else if (n_cur == NW'(1))
                    begin
                        rd_addr    = '0;
                        state_next = S_END;
                    end
                    else
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end

            S_END:
            begin
                res_next   = y_rd_s;
                state_next = S_EMIT;
            end

            S_SEARCH:
            begin
                if (count_reg == '0)
                begin
                    if (first_reg == '0)
                    begin
                        rd_addr    = '0;
                        state_next = S_END;
                    end
                    else if (first_reg >= n_reg)
                    begin
                        rd_addr    = first_m1[AW-1:0];
                        state_next = S_END;
                    end
                    else
                    begin
                        rd_addr    = first_m1[AW-1:0];
                        state_next = S_LOAD0;
                    end
                end
                else
                begin
                    step_next  = count_reg >> 1;
                    probe_next = probe_sum[AW-1:0];
                    rd_addr    = probe_sum[AW-1:0];
                    state_next = S_PROBE;
                end
            end

            S_PROBE:
            begin
                if (!(xq_reg < x_rd_s))
                begin
                    first_next = NW'(probe_reg) + NW'(1);
                    count_next = count_reg - step_reg - NW'(1);
                end
                else
                begin
                    count_next = step_reg;
                end
                state_next = S_SEARCH;
            end

            S_LOAD0:
            begin
                x0_next    = x_rd_s;
                y0_next    = y_rd_s;
                rd_addr    = first_reg[AW-1:0];
                state_next = S_LOAD1;
            end

            S_LOAD1:
            begin
                x1_next    = x_rd_s;
                y1_next    = y_rd_s;
                state_next = S_SETUP;
            end

            S_SETUP:
            begin
                dx_next    = x1_reg - x0_reg;
                num_next   = xq_reg - x0_reg;
                delta_next = y1_reg - y0_reg;
                state_next = S_CLAMP;
            end

            S_CLAMP:
            begin
                neg_next = delta_reg[WW-1];
                mag_next = delta_reg[WW-1] ? 32'(-delta_reg) : delta_reg[31:0];
                quo_next = '0;
                iter_next = '0;
                rem_next = num_reg[WW-1] ? '0 : $unsigned(num_reg);
                if (dx_reg <= 0)
                begin
                    res_next   = y0_reg;
                    state_next = S_EMIT;
                end
                else if (!num_reg[WW-1] && (num_reg >= dx_reg))
                begin
                    res_next   = y1_reg;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                rem_next  = div_fit ? (rem_sh - $unsigned(dx_reg)) : rem_sh;
                quo_next  = {quo_reg[30:0], div_fit};
                iter_next = iter_reg + 5'd1;
                if (iter_reg == 5'd31)
                begin
                    state_next = S_MULH;
                end
            end

            S_MULH:
            begin
                prod_hi_next = mul_p;
                state_next   = S_MULL;
            end

            S_MULL:
            begin
                prod_lo_next = mul_p;
                state_next   = S_SUM;
            end

            S_SUM:
            begin
                q_next     = sum_full[48:16];
                state_next = S_APPLY;
            end

            S_APPLY:
            begin
                res_next   = neg_reg ? (y0_reg - WW'(q_reg)) : (y0_reg + WW'(q_reg));
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (res_reg > SAT_HI)
                    begin
                        out_value_next  = SAT_HI[FIELD_W-1:0];
                        out_status_next = ST_SAT;
                    end
                    else if (res_reg < SAT_LO)
                    begin
                        out_value_next  = SAT_LO[FIELD_W-1:0];
                        out_status_next = ST_SAT;
                    end
                    else
                    begin
                        out_value_next  = res_reg[FIELD_W-1:0];
                        out_status_next = st_reg;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xq_reg         <= xq_next;
        n_reg          <= n_next;
        first_reg      <= first_next;
        count_reg      <= count_next;
        step_reg       <= step_next;
        probe_reg      <= probe_next;
        st_reg         <= st_next;
        res_reg        <= res_next;
        x0_reg         <= x0_next;
        y0_reg         <= y0_next;
        x1_reg         <= x1_next;
        y1_reg         <= y1_next;
        dx_reg         <= dx_next;
        num_reg        <= num_next;
        delta_reg      <= delta_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        iter_reg       <= iter_next;
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        prod_hi_reg    <= prod_hi_next;
        prod_lo_reg    <= prod_lo_next;
        q_reg          <= q_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign cmd.ready     = (state_reg == S_IDLE);
    assign result.valid  = out_valid_reg;
    assign result.value  = out_value_reg;
    assign result.status = out_status_reg;

endmodule

`default_nettype wire

// File: rtl/bli_checker.sv
`default_nettype none

module bli_checker
    import bli_pkg::*;
(
    input wire                clk,
    input wire                rst_n,
    input wire                cmd_valid,
    input wire                cmd_ready,
    input wire                cmd_operation,
    input wire                result_valid,
    input wire                result_ready,
    input wire [FIELD_W-1:0]  result_value,
    input wire [2:0]          result_status
);

    // An evaluate item keeps the block busy for at least the next cycle.
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_operation == OP_EVAL) |=> !cmd_ready)
        else $error("block still ready after taking an evaluate item");

    // After a write item the block is ready again in the next cycle.
    a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_operation == OP_WRITE) |=> cmd_ready)
        else $error("block busy after a write item");

    // A new result appears only at the end of an evaluation.
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !$past(cmd_ready))
        else $error("result appeared without a busy evaluation before it");

    // An empty table always reports a zero value.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_status == ST_EMPTY) |-> (result_value == '0))
        else $error("empty-table result with a nonzero value");

    // A stalled result holds.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(result_value) && $stable(result_status))
        else $error("stalled result changed");

endmodule

bind breakpoint_linear_interpolator bli_checker u_bli_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .cmd_operation (cmd.operation),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .result_value  (result.value),
    .result_status (result.status)
);

`default_nettype wire
